// File: sv/gpa_pkg.sv
// ----------------------------------------------------------------------------
// gpa_pkg
// Shared constants, codes and interface structs of the pool id allocator.
// ----------------------------------------------------------------------------
package gpa_pkg;

   localparam int MAX_ENTITIES = 1024;
   localparam int MAX_POOLS    = 8;
   localparam int ID_W         = $clog2(MAX_ENTITIES);
   localparam int WORD_W       = 32;
   localparam int BIT_W        = $clog2(WORD_W);
   localparam int ROWS         = MAX_ENTITIES / WORD_W;
   localparam int ROW_W        = $clog2(ROWS);
   localparam int POOL_W       = 3;
   localparam int CNT_W        = 4;
   localparam int PER_W        = 11;
   localparam int SIZE_W       = 21;
   localparam int OFF_W        = 30;
   localparam int USED_W       = 11;
   localparam int TOT_W        = 11;
   localparam int DIVC_W       = 2;

   typedef enum logic [1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_FREE    = 2'd1,
      KIND_INIT    = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_UNREG    = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_GROWFAIL = 3'd3,
      ST_BADID    = 3'd4,
      ST_DOUBLE   = 3'd5,
      ST_BADCFG   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      REG_POOL_COUNT = 2'd0,
      REG_PER_POOL   = 2'd1,
      REG_ENT_SIZE   = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_A_READ, S_F_READ, S_DIV, S_A_GROW, S_A_INC, S_F_DEC, S_F_REL, S_DONE
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]  pool_count;
      logic [PER_W-1:0]  per_pool;
      logic [SIZE_W-1:0] ent_size;
   } cfg_type;

   typedef struct packed {
      logic       start;
      logic       init;
      logic       release_all;
      logic       rd_row;
      logic       a_pick;
      logic       f_set;
      logic       div_step;
      logic       grow_eval;
      logic       mul;
      logic       a_commit;
      logic       f_dec;
      logic       rel_step;
      logic       use_p;
      logic       st_we;
      status_type st_code;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      kind_type in_kind;
      logic     unreg;
      logic     found;
      logic     eid_bad;
      logic     bit_free;
      logic     div_last;
      logic     a_fail;
      logic     rel_more;
      logic     out_free;
   } stat_type;

endpackage

// File: sv/gpa_ram.sv
// ----------------------------------------------------------------------------
// gpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, held between reads
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/gpa_ctrl.sv
// ----------------------------------------------------------------------------
// gpa_ctrl
// Sequencer: steps one transaction via lookup, divide, grow/commit or release.
// ----------------------------------------------------------------------------
module gpa_ctrl import gpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   // state and kind registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_ALLOC;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      cmd      = '0;
      cmd.st_code = ST_OK;
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               kind_in   = stat.in_kind;
               state_in  = S_DONE;
               unique case (stat.in_kind)
                  KIND_INIT:    cmd.init = 1'b1;
                  KIND_RELEASE: cmd.release_all = 1'b1;
                  KIND_ALLOC: begin
                     priority if (stat.unreg) begin
                        cmd.st_we = 1'b1;
                        cmd.st_code = ST_UNREG;
                     end else if (!stat.found) begin
                        cmd.st_we = 1'b1;
                        cmd.st_code = ST_EMPTY;
                     end else begin
                        cmd.rd_row = 1'b1;
                        state_in = S_A_READ;
                     end
                  end
                  KIND_FREE: begin
                     priority if (stat.unreg) begin
                        cmd.st_we = 1'b1;
                        cmd.st_code = ST_UNREG;
                     end else if (stat.eid_bad) begin
                        cmd.st_we = 1'b1;
                        cmd.st_code = ST_BADID;
                     end else begin
                        cmd.rd_row = 1'b1;
                        state_in = S_F_READ;
                     end
                  end
               endcase
            end
         end
         S_A_READ: begin
            cmd.a_pick = 1'b1;
            state_in = S_DIV;
         end
         S_F_READ: begin
            if (stat.bit_free) begin
               cmd.st_we = 1'b1;
               cmd.st_code = ST_DOUBLE;
               state_in = S_DONE;
            end else begin
               cmd.f_set = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = (kind_ff == KIND_ALLOC) ? S_A_GROW : S_F_DEC;
            end
         end
         S_A_GROW: begin
            cmd.grow_eval = 1'b1;
            cmd.mul = 1'b1;
            if (stat.a_fail) begin
               cmd.st_we = 1'b1;
               cmd.st_code = ST_GROWFAIL;
               state_in = S_DONE;
            end else begin
               state_in = S_A_INC;
            end
         end
         S_A_INC: begin
            cmd.a_commit = 1'b1;
            cmd.use_p = 1'b1;
            state_in = S_DONE;
         end
         S_F_DEC: begin
            cmd.f_dec = 1'b1;
            cmd.use_p = 1'b1;
            cmd.mul = 1'b1;
            state_in = S_F_REL;
         end
         S_F_REL: begin
            cmd.rel_step = 1'b1;
            if (!stat.rel_more) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: sv/gpa_dp.sv
// ----------------------------------------------------------------------------
// gpa_dp
// Datapath: free bitmap in RAM with row summary, pool counters, divider,
// offset multiplier and the result register.
// ----------------------------------------------------------------------------
module gpa_dp import gpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic [2:0]  rsp_tuser
);

   logic [ID_W-1:0] in_eid;
   logic            in_grow;

   logic                reg_ff, reg_in;
   logic [CNT_W-1:0]    backed_ff, backed_in;
   logic [CNT_W-1:0]    lat_pools_ff, lat_pools_in;
   logic [PER_W-1:0]    lat_per_ff, lat_per_in;
   logic [SIZE_W-1:0]   lat_size_ff, lat_size_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [ROWS-1:0]     valid_ff, valid_in;
   logic [ROWS-1:0]     sum_ff, sum_in;
   logic [USED_W-1:0]   used_ff [MAX_POOLS];
   logic [USED_W-1:0]   used_in [MAX_POOLS];
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                grow_ok_ff, grow_ok_in;
   logic [ID_W-1:0]     rem_ff, rem_in;
   logic [POOL_W-1:0]   quo_ff, quo_in;
   logic [DIVC_W-1:0]   cnt_ff, cnt_in;
   logic [OFF_W-1:0]    mul_ff, mul_in;
   status_type          res_st_ff, res_st_in;
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   logic [POOL_W-1:0]   res_pool_ff, res_pool_in;
   logic                res_off_ff, res_off_in;
   logic                res_grew_ff, res_grew_in;
   logic [CNT_W-1:0]    res_rel_ff, res_rel_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [55:0]         rsp_data_ff, rsp_data_in;
   logic [2:0]          rsp_user_ff, rsp_user_in;

   logic                found;
   logic [ROW_W-1:0]    low_row;
   logic [BIT_W-1:0]    low_bit;
   logic [WORD_W-1:0]   ram_rdata;
   logic [WORD_W-1:0]   eff_word;
   logic [WORD_W-1:0]   one_hot;
   logic                ram_we;
   logic [WORD_W-1:0]   ram_wdata;
   logic [ROW_W-1:0]    ram_raddr;
   logic [14:0]         tot_prod;
   logic                cfg_bad;
   logic [CNT_W-1:0]    bm1;
   logic [POOL_W-1:0]   used_addr;
   logic [USED_W-1:0]   used_rd;
   logic [13:0]         used5;
   logic [13:0]         per4;
   logic                grow_need;
   logic                grow_do;
   logic [CNT_W-1:0]    backed_next;
   logic [12:0]         trial;
   logic [ID_W+SIZE_W-1:0] mul_full;
   logic                rel_more;

   // ids below the registered total read as free until their row is written
   function automatic logic [WORD_W-1:0] init_word(input logic [ROW_W-1:0] row,
                                                   input logic [TOT_W-1:0] tot);
      logic [WORD_W-1:0] w;
      for (int b = 0; b < WORD_W; b++) begin
         w[b] = (TOT_W'({row, BIT_W'(b)}) < tot);
      end
      return w;
   endfunction

   assign in_eid  = req_tdata[ID_W-1:0];
   assign in_grow = req_tdata[ID_W];

   // lowest row with a free id
   always_comb begin
      found   = |sum_ff;
      low_row = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (sum_ff[r]) low_row = ROW_W'(r);
      end
   end

   assign eff_word = valid_ff[row_ff] ? ram_rdata : init_word(row_ff, total_ff);
   assign one_hot  = WORD_W'(1) << bit_ff;

   // lowest free bit in the fetched row
   always_comb begin
      low_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (eff_word[b]) low_bit = BIT_W'(b);
      end
   end

   assign ram_raddr = (req_tuser == KIND_ALLOC) ? low_row : in_eid[ID_W-1:BIT_W];
   assign ram_we    = cmd.a_commit | cmd.f_set;
   assign ram_wdata = cmd.a_commit ? (word_ff & ~one_hot) : (eff_word | one_hot);

   gpa_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (row_ff),
      .wdata (ram_wdata),
      .re    (cmd.rd_row),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // configuration check at init
   assign tot_prod = 15'(cfg.pool_count) * 15'(cfg.per_pool);
   assign cfg_bad  = (cfg.pool_count == '0) || (cfg.pool_count > CNT_W'(MAX_POOLS)) ||
                     (cfg.per_pool == '0) || (tot_prod > 15'(MAX_ENTITIES));

   // pool counter read port
   assign bm1       = backed_ff - 1'b1;
   assign used_addr = cmd.use_p ? quo_ff : bm1[POOL_W-1:0];
   assign used_rd   = used_ff[used_addr];

   // grow test: used > floor(4*per/5) is the same as 5*used > 4*per
   assign used5 = 14'(used_rd) + (14'(used_rd) << 2);
   assign per4  = 14'(lat_per_ff) << 2;
   assign grow_need = (backed_ff >= CNT_W'(1)) && (backed_ff < lat_pools_ff) &&
                      ((CNT_W'(quo_ff) + 1'b1) >= backed_ff) && (used5 > per4);
   assign grow_do     = grow_need && grow_ok_ff;
   assign backed_next = grow_do ? backed_ff + 1'b1 : backed_ff;

   assign trial    = 13'(lat_per_ff) << cnt_ff;
   assign mul_full = (ID_W+SIZE_W)'(rem_ff) * (ID_W+SIZE_W)'(lat_size_ff);
   assign rel_more = (backed_ff > CNT_W'(1)) && (used_rd == '0);

   // status to the controller
   always_comb begin
      stat.in_kind  = kind_type'(req_tuser);
      stat.unreg    = !reg_ff;
      stat.found    = found;
      stat.eid_bad  = (TOT_W'(in_eid) >= total_ff);
      stat.bit_free = eff_word[bit_ff];
      stat.div_last = (cnt_ff == '0);
      stat.a_fail   = (grow_need && !grow_ok_ff) || (CNT_W'(quo_ff) >= backed_next);
      stat.rel_more = rel_more;
      stat.out_free = !rsp_valid_ff || rsp_tready;
   end

   // next state of the datapath
   always_comb begin
      reg_in       = reg_ff;
      backed_in    = backed_ff;
      lat_pools_in = lat_pools_ff;
      lat_per_in   = lat_per_ff;
      lat_size_in  = lat_size_ff;
      total_in     = total_ff;
      valid_in     = valid_ff;
      sum_in       = sum_ff;
      used_in      = used_ff;
      row_in       = row_ff;
      bit_in       = bit_ff;
      word_in      = word_ff;
      grow_ok_in   = grow_ok_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      mul_in       = mul_ff;
      res_st_in    = res_st_ff;
      res_id_in    = res_id_ff;
      res_pool_in  = res_pool_ff;
      res_off_in   = res_off_ff;
      res_grew_in  = res_grew_ff;
      res_rel_in   = res_rel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      // capture the transaction and clear the result
      if (cmd.start) begin
         grow_ok_in  = in_grow;
         res_st_in   = ST_OK;
         res_id_in   = '0;
         res_pool_in = '0;
         res_off_in  = 1'b0;
         res_grew_in = 1'b0;
         res_rel_in  = '0;
      end
      if (cmd.st_we) res_st_in = cmd.st_code;

      // drop everything on init or release
      if (cmd.init || cmd.release_all) begin
         reg_in       = 1'b0;
         backed_in    = '0;
         lat_pools_in = '0;
         lat_per_in   = '0;
         lat_size_in  = '0;
         total_in     = '0;
         valid_in     = '0;
         sum_in       = '0;
         for (int p = 0; p < MAX_POOLS; p++) used_in[p] = '0;
      end
      if (cmd.release_all) res_rel_in = reg_ff ? backed_ff : '0;
      if (cmd.init) begin
         priority if (cfg_bad) begin
            res_st_in = ST_BADCFG;
         end else if (!in_grow) begin
            res_st_in = ST_GROWFAIL;
         end else begin
            lat_pools_in = cfg.pool_count;
            lat_per_in   = cfg.per_pool;
            lat_size_in  = cfg.ent_size;
            total_in     = tot_prod[TOT_W-1:0];
            for (int r = 0; r < ROWS; r++) begin
               sum_in[r] = (15'({ROW_W'(r), BIT_W'(0)}) < tot_prod);
            end
            backed_in   = CNT_W'(1);
            reg_in      = 1'b1;
            res_grew_in = 1'b1;
         end
      end

      // latch the row address of the lookup
      if (cmd.rd_row) begin
         row_in = ram_raddr;
         bit_in = in_eid[BIT_W-1:0];
      end

      // take the lowest free id and start the divide
      if (cmd.a_pick) begin
         bit_in  = low_bit;
         word_in = eff_word;
         rem_in  = {row_ff, low_bit};
      end
      if (cmd.f_set) begin
         rem_in        = {row_ff, bit_ff};
         valid_in[row_ff] = 1'b1;
         sum_in[row_ff]   = 1'b1;
      end
      if (cmd.a_pick || cmd.f_set) begin
         quo_in = '0;
         cnt_in = DIVC_W'(POOL_W - 1);
      end

      // one restoring quotient bit per step
      if (cmd.div_step) begin
         if (13'(rem_ff) >= trial) begin
            rem_in = rem_ff - trial[ID_W-1:0];
            quo_in[cnt_ff] = 1'b1;
         end
         cnt_in = cnt_ff - 1'b1;
      end

      if (cmd.mul) mul_in = mul_full[OFF_W-1:0];

      // back the next pool
      if (cmd.grow_eval && grow_do) begin
         used_in[backed_ff[POOL_W-1:0]] = '0;
         backed_in   = backed_ff + 1'b1;
         res_grew_in = 1'b1;
      end

      // commit the allocation
      if (cmd.a_commit) begin
         valid_in[row_ff] = 1'b1;
         sum_in[row_ff]   = |(word_ff & ~one_hot);
         used_in[quo_ff]  = used_rd + 1'b1;
         res_id_in   = {row_ff, bit_ff};
         res_pool_in = quo_ff;
         res_off_in  = 1'b1;
      end

      // return the id to its pool
      if (cmd.f_dec) begin
         if (used_rd != '0) used_in[quo_ff] = used_rd - 1'b1;
         res_pool_in = quo_ff;
         res_off_in  = 1'b1;
      end

      // release one trailing empty pool per cycle
      if (cmd.rel_step && rel_more) begin
         backed_in  = backed_ff - 1'b1;
         res_rel_in = res_rel_ff + 1'b1;
      end

      // hand the result to the output register
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = res_st_ff;
         rsp_data_in  = {4'b0, backed_ff, res_rel_ff, res_grew_ff,
                         (res_off_ff ? mul_ff : OFF_W'(0)), res_pool_ff, res_id_ff};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_ff       <= 1'b0;
         backed_ff    <= '0;
         lat_pools_ff <= '0;
         lat_per_ff   <= '0;
         lat_size_ff  <= '0;
         total_ff     <= '0;
         valid_ff     <= '0;
         sum_ff       <= '0;
         for (int p = 0; p < MAX_POOLS; p++) used_ff[p] <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reg_ff       <= reg_in;
         backed_ff    <= backed_in;
         lat_pools_ff <= lat_pools_in;
         lat_per_ff   <= lat_per_in;
         lat_size_ff  <= lat_size_in;
         total_ff     <= total_in;
         valid_ff     <= valid_in;
         sum_ff       <= sum_in;
         used_ff      <= used_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      bit_ff      <= bit_in;
      word_ff     <= word_in;
      grow_ok_ff  <= grow_ok_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      mul_ff      <= mul_in;
      res_st_ff   <= res_st_in;
      res_id_ff   <= res_id_in;
      res_pool_ff <= res_pool_in;
      res_off_ff  <= res_off_in;
      res_grew_ff <= res_grew_in;
      res_rel_ff  <= res_rel_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: sv/growing_pool_id_allocator.sv
// ----------------------------------------------------------------------------
// growing_pool_id_allocator
// Lowest-free id allocator over equal pools that are backed and released in
// order; one result transaction for each request transaction.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/tready     | tdata: entity_id, grow_ok; tuser: kind
//  rsp     | out | rsp_tvalid/tready     | tdata: ids, pools, offset; tuser: status
//  csr     | in  | psel/penable/pready   | pool_count, entities_per_pool, ent_size
//
// Init, release and requests rejected at once (unregistered, none free, bad
// id) go straight to the result; a double free ends after the row read; alloc
// runs row read, 3-step quotient divider, grow check and commit, ending at the
// grow check if it fails; free runs row read, divider and decrement, then a
// loop over the single pool counter read port releases trailing empty pools
// one at a time. One transaction is in work at a time. Reset is synchronous;
// the bitmap rows reload from the valid bits, so no clearing pass is needed.
// A stalled result holds in the output register as the next request is taken.
// ----------------------------------------------------------------------------
module growing_pool_id_allocator import gpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] entity_id, [10] grow_ok
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [9:0] given_id, [12:10] pool_of_id,
                                    // [42:13] byte_offset, [43] grew_pool,
                                    // [47:44] pools_released, [51:48] pools_in_use
   output logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   cmd_type       cmd;
   stat_type      stat;
   reg_index_type csr_idx;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_POOL_COUNT: cfg_in.pool_count = csr_pwdata[CNT_W-1:0];
            REG_PER_POOL:   cfg_in.per_pool   = csr_pwdata[PER_W-1:0];
            REG_ENT_SIZE:   cfg_in.ent_size   = csr_pwdata[SIZE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pool_count <= CNT_W'(1);
         cfg_ff.per_pool   <= PER_W'(1024);
         cfg_ff.ent_size   <= SIZE_W'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         REG_POOL_COUNT: csr_prdata = 32'(cfg_ff.pool_count);
         REG_PER_POOL:   csr_prdata = 32'(cfg_ff.per_pool);
         REG_ENT_SIZE:   csr_prdata = 32'(cfg_ff.ent_size);
         default:        csr_prdata = '0;
      endcase
   end

   gpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gpa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // an accepted request keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in work");

   // never more pools in use than exist
   a_pools_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[51:48] <= 4'(MAX_POOLS)))
      else $error("pools_in_use out of range");

   // failed requests carry no id and no offset
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata[42:0] == '0))
      else $error("failed result carries payload");

   // a result is loaded only while the datapath reports a free output
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result register overwritten");

endmodule
